/* rtl/ortt_pkg.sv */
`default_nettype none
package ortt_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 16;

    // angle datapath
    localparam int TURN_W = ANGLE_WIDTH - 2;
    localparam int XM_W = TURN_W + 31;
    localparam logic [30:0] HALF_PI = 31'd1686629713;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam int ROUND_Q14 = 8192;
    localparam int HSTEPS = 4;
    localparam logic [6:0] K_SIN [HSTEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [6:0] K_COS [HSTEPS] = '{7'd90, 7'd56, 7'd30, 7'd12};
    localparam logic [31:0] R_SIN [HSTEPS] = '{
        32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
        32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};
    localparam logic [31:0] R_COS [HSTEPS] = '{
        32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56),
        32'((64'd1 << 32) / 30), 32'((64'd1 << 32) / 12)};

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // one extra bit so that a negated -1.0 still fits
    localparam int TRIG_W = 19;
    localparam logic signed [TRIG_W-1:0] COS_ONE = TRIG_W'(65536);
    localparam int TRIG_LAT = 2 + 3 * HSTEPS + 2;

    // geometry datapath
    localparam int SZ_W = COORD_WIDTH - 1;
    localparam int CEN_W = COORD_WIDTH + 2;
    localparam int MUL_W = COORD_WIDTH + TRIG_W;
    localparam int RND_W = MUL_W + 2;
    localparam int ROUND_Q16 = 32768;
    localparam int OFF_W = RND_W - 16;
    localparam int PT_W = ((CEN_W > OFF_W) ? CEN_W : OFF_W) + 1;
    localparam int DOT_W = PT_W + TRIG_W + 1;
    localparam int GEO_STAGES = 7;
    localparam int TOTAL_LAT = TRIG_LAT + GEO_STAGES;

    // corner order: (-w,+h) (+w,+h) (+w,-h) (-w,-h)
    localparam logic [3:0] SX_NEG = 4'b1001;
    localparam logic [3:0] SY_NEG = 4'b1100;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [MUL_W-1:0] mul_t;
    typedef logic signed [OFF_W-1:0] off_t;
    typedef logic signed [CEN_W-1:0] cen_t;
    typedef logic signed [PT_W-1:0] point_t;
    typedef logic signed [DOT_W-1:0] dot_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] left;
        logic signed [COORD_WIDTH-1:0] top;
        logic [SZ_W-1:0]               width;
        logic [SZ_W-1:0]               height;
    } rect_in_t;

endpackage
`default_nettype wire

/* rtl/ortt_trig.sv */
`default_nettype none
module ortt_trig
    import ortt_pkg::*;
(
    input  logic                   clk,
    input  logic [ANGLE_WIDTH-1:0] turn,
    output trig_t                  cs,
    output trig_t                  sn
);

    logic [XM_W-1:0] xm_reg;
    logic [1:0]      q1_reg;
    logic [30:0]     x_reg;
    logic [61:0]     x2p_reg;
    logic [1:0]      q2_reg;
    logic [30:0]     x_w;

    logic [30:0] hx_reg  [HSTEPS];
    logic [31:0] hx2_reg [HSTEPS];
    logic [1:0]  hq_reg  [HSTEPS];
    logic [30:0] hvs_reg [HSTEPS];
    logic [30:0] hvc_reg [HSTEPS];

    assign x_w = xm_reg[XM_W-1 -: 31];

    always_ff @(posedge clk)
    begin
        xm_reg  <= XM_W'(turn[TURN_W-1:0]) * XM_W'(HALF_PI);
        q1_reg  <= turn[ANGLE_WIDTH-1 -: 2];
        x_reg   <= x_w;
        x2p_reg <= 62'(x_w) * 62'(x_w);
        q2_reg  <= q1_reg;
    end

    // one Horner step per block: multiply, reciprocal multiply, correct
    for (genvar i = 0; i < HSTEPS; i++)
    begin : g_step
        logic [30:0] in_x;
        logic [31:0] in_x2;
        logic [1:0]  in_q;
        logic [30:0] in_vs;
        logic [30:0] in_vc;
        logic [62:0] ps;
        logic [62:0] pc;
        logic [30:0] ax_reg;
        logic [31:0] ax2_reg;
        logic [1:0]  aq_reg;
        logic [31:0] ys_reg;
        logic [31:0] yc_reg;
        logic [63:0] qps;
        logic [63:0] qpc;
        logic [30:0] bx_reg;
        logic [31:0] bx2_reg;
        logic [1:0]  bq_reg;
        logic [31:0] bys_reg;
        logic [31:0] byc_reg;
        logic [31:0] qs_reg;
        logic [31:0] qc_reg;
        logic [31:0] rs;
        logic [31:0] rc;
        logic [31:0] fs;
        logic [31:0] fc;

        if (i == 0)
        begin : g_first
            assign in_x  = x_reg;
            assign in_x2 = x2p_reg[61:30];
            assign in_q  = q2_reg;
            assign in_vs = ONE_Q30;
            assign in_vc = ONE_Q30;
        end
        else
        begin : g_next
            assign in_x  = hx_reg[i-1];
            assign in_x2 = hx2_reg[i-1];
            assign in_q  = hq_reg[i-1];
            assign in_vs = hvs_reg[i-1];
            assign in_vc = hvc_reg[i-1];
        end

        assign ps  = 63'(in_x2) * 63'(in_vs);
        assign pc  = 63'(in_x2) * 63'(in_vc);
        assign qps = 64'(ys_reg) * 64'(R_SIN[i]);
        assign qpc = 64'(yc_reg) * 64'(R_COS[i]);
        // estimate is at most one short: fix with one compare
        assign rs  = bys_reg - 32'(qs_reg * 32'(K_SIN[i]));
        assign rc  = byc_reg - 32'(qc_reg * 32'(K_COS[i]));
        assign fs  = qs_reg + 32'(rs >= 32'(K_SIN[i]));
        assign fc  = qc_reg + 32'(rc >= 32'(K_COS[i]));

        always_ff @(posedge clk)
        begin
            ax_reg  <= in_x;
            ax2_reg <= in_x2;
            aq_reg  <= in_q;
            ys_reg  <= ps[61:30];
            yc_reg  <= pc[61:30];

            bx_reg  <= ax_reg;
            bx2_reg <= ax2_reg;
            bq_reg  <= aq_reg;
            bys_reg <= ys_reg;
            byc_reg <= yc_reg;
            qs_reg  <= qps[63:32];
            qc_reg  <= qpc[63:32];

            hx_reg[i]  <= bx_reg;
            hx2_reg[i] <= bx2_reg;
            hq_reg[i]  <= bq_reg;
            hvs_reg[i] <= ONE_Q30 - 31'(fs);
            hvc_reg[i] <= ONE_Q30 - 31'(fc);
        end
    end

    logic [61:0] sp_reg;
    logic [62:0] cp_reg;
    logic [1:0]  fq_reg;
    logic [31:0] s_raw;
    logic [31:0] s_cl;
    logic [31:0] s_sum;
    logic [30:0] d;
    logic [30:0] c_cl;
    logic [31:0] c_sum;
    trig_t       s_pos;
    trig_t       c_pos;
    trig_t       cs_reg;
    trig_t       sn_reg;

    always_ff @(posedge clk)
    begin
        sp_reg <= 62'(hx_reg[HSTEPS-1]) * 62'(hvs_reg[HSTEPS-1]);
        cp_reg <= 63'(hx2_reg[HSTEPS-1]) * 63'(hvc_reg[HSTEPS-1]);
        fq_reg <= hq_reg[HSTEPS-1];
    end

    always_comb
    begin
        s_raw = sp_reg[61:30];
        s_cl  = (s_raw > 32'(ONE_Q30)) ? 32'(ONE_Q30) : s_raw;
        s_sum = s_cl + 32'(ROUND_Q14);
        d     = cp_reg[61:31];
        c_cl  = (d > ONE_Q30) ? 31'd0 : ONE_Q30 - d;
        c_sum = 32'(c_cl) + 32'(ROUND_Q14);
        s_pos = TRIG_W'(s_sum[30:14]);
        c_pos = TRIG_W'(c_sum[30:14]);
    end

    always_ff @(posedge clk)
    begin
        unique case (fq_reg)
            QUAD_0:
            begin
                cs_reg <= c_pos;
                sn_reg <= s_pos;
            end
            QUAD_1:
            begin
                cs_reg <= -s_pos;
                sn_reg <= c_pos;
            end
            QUAD_2:
            begin
                cs_reg <= -c_pos;
                sn_reg <= -s_pos;
            end
            QUAD_3:
            begin
                cs_reg <= s_pos;
                sn_reg <= -c_pos;
            end
            default:
            begin
                cs_reg <= c_pos;
                sn_reg <= s_pos;
            end
        endcase
    end

    assign cs = cs_reg;
    assign sn = sn_reg;

endmodule
`default_nettype wire

/* rtl/oriented_rect_overlap_test_top.sv */
// Separating-axis overlap test for two rotated rectangles. A pair is taken on
// every clock edge with start high (busy is always low) and its verdict appears
// on overlap after the pipeline, marked by a one-cycle done strobe; the receiver
// cannot stall, so results must be taken as they come. Throughput is one pair
// per cycle. The pipeline is the sine/cosine unit (angle scaling and squaring,
// four Horner steps of three stages each, the final products and the quadrant
// fold) followed by seven geometry stages: edge products, rounded corner
// offsets, corner positions, dot products and a two-level min/max tree with
// the final interval compare.
`default_nettype none
module oriented_rect_overlap_test_top
    import ortt_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] a_left,
    input  logic signed [COORD_WIDTH-1:0] a_top,
    input  logic [SZ_W-1:0]               a_width,
    input  logic [SZ_W-1:0]               a_height,
    input  logic [ANGLE_WIDTH-1:0]        a_turn,
    input  logic signed [COORD_WIDTH-1:0] b_left,
    input  logic signed [COORD_WIDTH-1:0] b_top,
    input  logic [SZ_W-1:0]               b_width,
    input  logic [SZ_W-1:0]               b_height,
    input  logic [ANGLE_WIDTH-1:0]        b_turn,
    output logic                          done,
    output logic                          overlap
);

    function automatic off_t corner_off(mul_t pa, logic na, mul_t pb, logic nb);
        logic signed [RND_W-1:0] ea;
        logic signed [RND_W-1:0] eb;
        logic signed [RND_W-1:0] u;
        ea = RND_W'(pa);
        eb = RND_W'(pb);
        if (na)
            ea = -ea;
        if (nb)
            eb = -eb;
        u = ea + eb + RND_W'(ROUND_Q16);
        // arithmetic part-select floors, so ties round upward
        return u[RND_W-1:16];
    endfunction

    logic  vld_reg [TOTAL_LAT];
    trig_t cs_w [2];
    trig_t sn_w [2];

    rect_in_t dl_reg [TRIG_LAT][2];

    mul_t wc_reg [2];
    mul_t hs_reg [2];
    mul_t ws_reg [2];
    mul_t hc_reg [2];
    cen_t cx_reg [2];
    cen_t cy_reg [2];
    trig_t csm_reg [2];
    trig_t snm_reg [2];

    off_t ox_reg [2][4];
    off_t oy_reg [2][4];
    cen_t cxr_reg [2];
    cen_t cyr_reg [2];
    trig_t csr_reg [2];
    trig_t snr_reg [2];

    point_t px_reg [2][4];
    point_t py_reg [2][4];
    trig_t csc_reg [2];
    trig_t snc_reg [2];

    trig_t ax_w [4];
    trig_t ay_w [4];
    dot_t dot_reg [4][2][4];
    dot_t lo2_reg [4][2][2];
    dot_t hi2_reg [4][2][2];
    dot_t lo_reg [4][2];
    dot_t hi_reg [4][2];
    logic [3:0] sep;
    logic overlap_reg;

    ortt_trig u_trig_a (
        .clk  (clk),
        .turn (a_turn),
        .cs   (cs_w[0]),
        .sn   (sn_w[0])
    );

    ortt_trig u_trig_b (
        .clk  (clk),
        .turn (b_turn),
        .cs   (cs_w[1]),
        .sn   (sn_w[1])
    );

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TOTAL_LAT; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start;
            for (int s = 1; s < TOTAL_LAT; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // hold the rectangle positions and sizes until the angle unit catches up
    always_ff @(posedge clk)
    begin
        dl_reg[0][0] <= '{left: a_left, top: a_top, width: a_width, height: a_height};
        dl_reg[0][1] <= '{left: b_left, top: b_top, width: b_width, height: b_height};
        for (int s = 1; s < TRIG_LAT; s++)
            dl_reg[s] <= dl_reg[s-1];
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 2; r++)
        begin
            wc_reg[r]  <= MUL_W'(dl_reg[TRIG_LAT-1][r].width) * MUL_W'(cs_w[r]);
            hs_reg[r]  <= MUL_W'(dl_reg[TRIG_LAT-1][r].height) * MUL_W'(sn_w[r]);
            ws_reg[r]  <= MUL_W'(dl_reg[TRIG_LAT-1][r].width) * MUL_W'(sn_w[r]);
            hc_reg[r]  <= MUL_W'(dl_reg[TRIG_LAT-1][r].height) * MUL_W'(cs_w[r]);
            cx_reg[r]  <= (CEN_W'(dl_reg[TRIG_LAT-1][r].left) <<< 1)
                          + CEN_W'(dl_reg[TRIG_LAT-1][r].width);
            cy_reg[r]  <= (CEN_W'(dl_reg[TRIG_LAT-1][r].top) <<< 1)
                          + CEN_W'(dl_reg[TRIG_LAT-1][r].height);
            csm_reg[r] <= cs_w[r];
            snm_reg[r] <= sn_w[r];

            for (int i = 0; i < 4; i++)
            begin
                ox_reg[r][i] <= corner_off(wc_reg[r], SX_NEG[i], hs_reg[r], !SY_NEG[i]);
                oy_reg[r][i] <= corner_off(ws_reg[r], SX_NEG[i], hc_reg[r], SY_NEG[i]);
            end
            cxr_reg[r] <= cx_reg[r];
            cyr_reg[r] <= cy_reg[r];
            csr_reg[r] <= csm_reg[r];
            snr_reg[r] <= snm_reg[r];

            for (int i = 0; i < 4; i++)
            begin
                px_reg[r][i] <= PT_W'(cxr_reg[r]) + PT_W'(ox_reg[r][i]);
                py_reg[r][i] <= PT_W'(cyr_reg[r]) + PT_W'(oy_reg[r][i]);
            end
            csc_reg[r] <= csr_reg[r];
            snc_reg[r] <= snr_reg[r];
        end
    end

    // edge directions of both rectangles
    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            ax_w[2*r]   = csc_reg[r];
            ay_w[2*r]   = snc_reg[r];
            ax_w[2*r+1] = -snc_reg[r];
            ay_w[2*r+1] = csc_reg[r];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int r = 0; r < 2; r++)
            begin
                for (int i = 0; i < 4; i++)
                    dot_reg[k][r][i] <= DOT_W'(px_reg[r][i]) * DOT_W'(ax_w[k])
                                        + DOT_W'(py_reg[r][i]) * DOT_W'(ay_w[k]);
                for (int j = 0; j < 2; j++)
                begin
                    lo2_reg[k][r][j] <= (dot_reg[k][r][2*j] < dot_reg[k][r][2*j+1])
                                        ? dot_reg[k][r][2*j] : dot_reg[k][r][2*j+1];
                    hi2_reg[k][r][j] <= (dot_reg[k][r][2*j] > dot_reg[k][r][2*j+1])
                                        ? dot_reg[k][r][2*j] : dot_reg[k][r][2*j+1];
                end
                lo_reg[k][r] <= (lo2_reg[k][r][0] < lo2_reg[k][r][1])
                                ? lo2_reg[k][r][0] : lo2_reg[k][r][1];
                hi_reg[k][r] <= (hi2_reg[k][r][0] > hi2_reg[k][r][1])
                                ? hi2_reg[k][r][0] : hi2_reg[k][r][1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            sep[k] = (hi_reg[k][0] < lo_reg[k][1]) || (lo_reg[k][0] > hi_reg[k][1]);
    end

    always_ff @(posedge clk)
    begin
        overlap_reg <= ~(|sep);
    end

    assign done    = vld_reg[TOTAL_LAT-1];
    assign overlap = overlap_reg;

`ifndef SYNTH
    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##TOTAL_LAT done)
        else $error("accepted beat produced no result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result without an accepted beat");
    a_zero_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (a_turn == '0) |-> ##TRIG_LAT (cs_w[0] == COS_ONE && sn_w[0] == '0))
        else $error("zero rotation did not give unit cosine");
`endif

endmodule
`default_nettype wire

/* test/overlap_checker.sv */
`timescale 1ns / 100ps
module overlap_checker
    import ortt_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] a_left,
    input  logic signed [COORD_WIDTH-1:0] a_top,
    input  logic [SZ_W-1:0]               a_width,
    input  logic [SZ_W-1:0]               a_height,
    input  logic [ANGLE_WIDTH-1:0]        a_turn,
    input  logic signed [COORD_WIDTH-1:0] b_left,
    input  logic signed [COORD_WIDTH-1:0] b_top,
    input  logic [SZ_W-1:0]               b_width,
    input  logic [SZ_W-1:0]               b_height,
    input  logic [ANGLE_WIDTH-1:0]        b_turn,
    input  logic                          done,
    input  logic                          overlap,
    output int                            fail_count,
    output int                            pending
);

    typedef struct {
        longint px[4];
        longint py[4];
        longint cs;
        longint sn;
    } shape_t;

    bit verdicts[$];

    function automatic longint unsigned horner(longint unsigned x2, longint unsigned v,
                                               longint unsigned k);
        return 64'h4000_0000 - (((x2 * v) >> 30) / k);
    endfunction

    function automatic void turn_trig(logic [ANGLE_WIDTH-1:0] turn, output longint co,
                                      output longint si);
        longint unsigned one, t, x, x2, v, s, c, d;
        logic [1:0] q;
        one = 64'h4000_0000;
        q = turn[ANGLE_WIDTH-1 -: 2];
        t = turn[ANGLE_WIDTH-3:0];
        x = (t * 64'd1686629713) >> (ANGLE_WIDTH - 2);
        x2 = (x * x) >> 30;
        v = one;
        v = horner(x2, v, 72);
        v = horner(x2, v, 42);
        v = horner(x2, v, 20);
        v = horner(x2, v, 6);
        s = (x * v) >> 30;
        if (s > one)
            s = one;
        v = one;
        v = horner(x2, v, 90);
        v = horner(x2, v, 56);
        v = horner(x2, v, 30);
        v = horner(x2, v, 12);
        d = ((x2 * v) >> 30) / 2;
        c = (d > one) ? 0 : one - d;
        s = (s + 8192) >> 14;
        c = (c + 8192) >> 14;
        case (q)
            QUAD_0:  begin co = c;  si = s;  end
            QUAD_1:  begin co = -s; si = c;  end
            QUAD_2:  begin co = -c; si = -s; end
            default: begin co = s;  si = -c; end
        endcase
    endfunction

    function automatic longint rnd16(longint v);
        longint u;
        u = v + 32768;
        if (u >= 0)
            return u >>> 16;
        return -(((-u) + 65535) >>> 16);
    endfunction

    function automatic shape_t make_shape(longint left, longint top, longint w, longint h,
                                          logic [ANGLE_WIDTH-1:0] turn);
        shape_t r;
        longint dx, dy, cx, cy;
        cx = 2 * left + w;
        cy = 2 * top + h;
        turn_trig(turn, r.cs, r.sn);
        for (int i = 0; i < 4; i++)
        begin
            dx = SX_NEG[i] ? -w : w;
            dy = SY_NEG[i] ? -h : h;
            r.px[i] = cx + rnd16(dx * r.cs - dy * r.sn);
            r.py[i] = cy + rnd16(dx * r.sn + dy * r.cs);
        end
        return r;
    endfunction

    function automatic bit axis_gap(shape_t ra, shape_t rb, longint ax, longint ay);
        longint pa, pb, mina, maxa, minb, maxb;
        for (int i = 0; i < 4; i++)
        begin
            pa = ra.px[i] * ax + ra.py[i] * ay;
            pb = rb.px[i] * ax + rb.py[i] * ay;
            if (i == 0 || pa < mina) mina = pa;
            if (i == 0 || pa > maxa) maxa = pa;
            if (i == 0 || pb < minb) minb = pb;
            if (i == 0 || pb > maxb) maxb = pb;
        end
        return (maxa < minb) || (mina > maxb);
    endfunction

    function automatic bit predict_overlap();
        shape_t ra, rb;
        ra = make_shape(a_left, a_top, a_width, a_height, a_turn);
        rb = make_shape(b_left, b_top, b_width, b_height, b_turn);
        if (axis_gap(ra, rb, ra.cs, ra.sn) || axis_gap(ra, rb, -ra.sn, ra.cs) ||
            axis_gap(ra, rb, rb.cs, rb.sn) || axis_gap(ra, rb, -rb.sn, rb.cs))
            return 1'b0;
        return 1'b1;
    endfunction

    assign pending = verdicts.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        bit want;
        if (rst_n)
        begin
            if (done)
            begin
                if (verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected beat: overlap=%0b", overlap);
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (overlap !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("overlap mismatch: expected %0b, got %0b", want, overlap);
                    end
                end
            end
            if (start && !busy)
                verdicts.push_back(predict_overlap());
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
module testbench;
    import ortt_pkg::*;

    localparam int LATENCY = TOTAL_LAT;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, done, overlap;
    logic signed [COORD_WIDTH-1:0] a_left = '0, a_top = '0, b_left = '0, b_top = '0;
    logic [SZ_W-1:0] a_width = '0, a_height = '0, b_width = '0, b_height = '0;
    logic [ANGLE_WIDTH-1:0] a_turn = '0, b_turn = '0;
    int fail_count, pending;
    int cycles = 0;

    oriented_rect_overlap_test_top u_top (.*);
    overlap_checker u_check (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [23:0] rnd_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 4096)) - 2048);
            default: return 24'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
        endcase
    endfunction

    function automatic logic [22:0] rnd_size(int mode);
        case (mode)
            0: return 23'($urandom);
            1: return 23'($urandom_range(0, 2048));
            default: return 23'($urandom_range(0, 1 << 15));
        endcase
    endfunction

    // hold the beat until it is taken
    task automatic send_pair(logic [23:0] al, logic [23:0] at, logic [22:0] aw,
                             logic [22:0] ah, logic [15:0] ar, logic [23:0] bl,
                             logic [23:0] bt, logic [22:0] bw, logic [22:0] bh,
                             logic [15:0] br);
        a_left = al; a_top = at; a_width = aw; a_height = ah; a_turn = ar;
        b_left = bl; b_top = bt; b_width = bw; b_height = bh; b_turn = br;
        start = 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic maybe_idle(bit quiet);
        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    initial
    begin
        int m;
        logic [15:0] turns [8];
        turns = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                  16'hFFFF, 16'h3FFF, 16'h2000, 16'h0001};
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // extremes, degenerate shapes, touching edges, every quadrant
        send_pair(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 16'h0000,
                  24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF);
        send_pair(24'h7FFFFF, 24'h7FFFFF, '0, '0, '0, 24'h800000, 24'h800000, '0, '0, '0);
        send_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        send_pair('0, '0, 23'd256, 23'd256, '0, 24'd256, '0, 23'd256, 23'd256, '0);
        send_pair('0, '0, 23'd256, 23'd256, '0, 24'd257, '0, 23'd256, 23'd256, '0);
        send_pair('0, '0, 23'd512, '0, 16'h2000, 24'd128, '0, '0, 23'd512, '0);
        for (int i = 0; i < 8; i++)
            send_pair('0, '0, 23'd1024, 23'd256, turns[i], 24'd900, 24'd200,
                      23'd512, 23'd512, turns[7 - i]);
        for (int i = 0; i < 1200; i++)
        begin
            m = $urandom_range(0, 9);
            m = (m == 0) ? 0 : (m < 5 ? 1 : 2);
            send_pair(rnd_coord(m), rnd_coord(m), rnd_size(m), rnd_size(m), 16'($urandom),
                      rnd_coord(m), rnd_coord(m), rnd_size(m), rnd_size(m), 16'($urandom));
            maybe_idle(i >= 400 && i < 600);
        end
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/ortt_pkg.sv
rtl/ortt_trig.sv
rtl/oriented_rect_overlap_test_top.sv
test/overlap_checker.sv
test/testbench.sv
